@@ rtl/bia_pkg.sv @@
// Shared types and constants of the bitmap identifier allocator.
package bia_pkg;

  // Field widths fixed by the word formats
  localparam int ID_W   = 16;
  localparam int CNT_W  = 14;
  localparam int CIDX_W = 8;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_BASE_ID  = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_ID_COUNT = 8'd1;

  // Register values after reset
  localparam logic [ID_W-1:0]  BASE_ID_RST  = 16'd300;
  localparam logic [CNT_W-1:0] ID_COUNT_RST = 14'd4701;

  // Result codes
  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  typedef struct packed {
    logic            req_type;
    logic [ID_W-1:0] id_in;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0] id_out;
    status_t         status;
  } out_word_t;

  typedef struct packed {
    logic [CIDX_W-1:0] index;
    logic [ID_W-1:0]   value;
  } cfg_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic scan_issue;
    logic set_none;
    logic wr_alloc;
    logic rel_div;
    logic rel_read;
    logic set_invalid;
    logic rel_write;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_valid;
    logic in_rel;
    logic iss_done;
    logic chk_valid;
    logic hit;
    logic in_range;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/bia_in_if.sv @@
// Request channel interface: valid, ready and one request word.
interface bia_in_if import bia_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bia_out_if.sv @@
// Result channel interface: valid, ready and one result word.
interface bia_out_if import bia_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bia_cfg_if.sv @@
// Configuration write channel interface: valid, ready, register index and data.
interface bia_cfg_if import bia_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bia_ctrl.sv @@
// Sequencing state machine of the bitmap identifier allocator.
module bia_ctrl import bia_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_RDIV,
    S_RREAD,
    S_RWRITE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Command decode and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.accept   = stat.in_valid;
        if (stat.in_valid) begin
          state_nxt = stat.in_rel ? S_RDIV : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = !stat.hit && !stat.iss_done;
        cmd.set_none   = !stat.hit && stat.iss_done && !stat.chk_valid;
        if (stat.hit) begin
          state_nxt = S_ALLOC;
        end else if (stat.iss_done && !stat.chk_valid) begin
          state_nxt = S_DONE;
        end
      end
      S_ALLOC: begin
        cmd.wr_alloc = 1'b1;
        state_nxt    = S_DONE;
      end
      S_RDIV: begin
        cmd.rel_div = 1'b1;
        state_nxt   = S_RREAD;
      end
      S_RREAD: begin
        cmd.rel_read    = stat.in_range;
        cmd.set_invalid = !stat.in_range;
        state_nxt       = stat.in_range ? S_RWRITE : S_DONE;
      end
      S_RWRITE: begin
        cmd.rel_write = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        cmd.load_out = stat.out_free;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/bia_dp.sv @@
// Datapath: configuration registers, bitmap memory, scan logic and result registers.
module bia_dp import bia_pkg::*; #(
  parameter int MAP_BITS  = 8192,
  parameter int WORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  bia_in_if.sink        in_if,
  bia_out_if.source     out_if,
  bia_cfg_if.sink       cfg_if,
  input  dp_cmd_t       cmd,
  output dp_stat_t      stat
);

  localparam int MW    = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (MW > 1) ? $clog2(MW) : 1;
  localparam int BW    = $clog2(WORD_BITS);
  localparam int TB    = $clog2(MW * WORD_BITS + 1);
  localparam int XW    = (TB > CNT_W) ? TB : CNT_W;
  localparam int OW    = (TB > ID_W) ? TB : ID_W;
  localparam int DIV_S = ID_W + BW;
  localparam int DIV_M = (2 ** DIV_S + WORD_BITS - 1) / WORD_BITS;
  localparam int PW    = ID_W + DIV_S + 1;

  // Configuration registers
  logic [ID_W-1:0]  base_id_r;
  logic [CNT_W-1:0] id_count_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r  <= BASE_ID_RST;
      id_count_r <= ID_COUNT_RST;
    end else if (cfg_if.valid) begin
      if (cfg_if.data.index == CFG_BASE_ID) begin
        base_id_r <= cfg_if.data.value;
      end else if (cfg_if.data.index == CFG_ID_COUNT) begin
        id_count_r <= cfg_if.data.value[CNT_W-1:0];
      end
    end
  end

  // Effective count, clipped to the map size
  logic [XW-1:0] cnt_ext;
  logic [TB-1:0] n_bits;
  assign cnt_ext = XW'(id_count_r);
  assign n_bits  = (cnt_ext > XW'(MAP_BITS)) ? TB'(MAP_BITS) : TB'(cnt_ext);

  // Bitmap memory; words at or above the fill mark read as all free
  logic [WORD_BITS-1:0] mem [MW];
  logic [AW:0]          fill_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_zero_r;
  logic [AW-1:0]        rd_addr_q_r;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_addr_q_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_zero_r   <= ({1'b0, rd_addr} >= fill_r);
      rd_addr_q_r <= rd_addr;
    end
  end

  // Request word capture
  logic [ID_W-1:0] off_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      off_r <= in_if.data.id_in - base_id_r;
    end
  end

  assign in_if.ready = cmd.in_ready;

  // Scan address and bit position counters
  logic [AW-1:0] scan_addr_r;
  logic [TB-1:0] iss_bit_r;
  logic [TB-1:0] chk_bit_r;
  logic          chk_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_valid_r <= 1'b0;
    end else begin
      chk_valid_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_addr_r <= '0;
      iss_bit_r   <= '0;
    end else if (cmd.scan_issue) begin
      scan_addr_r <= scan_addr_r + AW'(1);
      iss_bit_r   <= iss_bit_r + TB'(WORD_BITS);
      chk_bit_r   <= iss_bit_r;
    end
  end

  // Free bit search in the word just read
  logic [WORD_BITS-1:0] data_eff;
  logic [TB-1:0]        rem;
  logic [WORD_BITS-1:0] free_v;
  logic [WORD_BITS-1:0] low_v;
  logic [BW-1:0]        hit_b;

  assign data_eff = rd_zero_r ? '0 : rd_data_r;
  assign rem      = n_bits - chk_bit_r;
  assign low_v    = free_v & (~free_v + WORD_BITS'(1));

  always_comb begin
    free_v = '0;
    hit_b  = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      free_v[b] = !data_eff[b] && (TB'(b) < rem);
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      if (low_v[b]) begin
        hit_b = hit_b | BW'(b);
      end
    end
  end

  // Release: word index by reciprocal multiply, then bit within the word
  logic [PW-1:0] prod;
  logic [AW-1:0] q_r;
  logic          in_range_r;
  logic [BW-1:0] r_r;
  logic [ID_W-1:0] q_base;

  assign prod   = PW'(off_r) * PW'(DIV_M);
  assign q_base = ID_W'(q_r) * ID_W'(WORD_BITS);

  always_ff @(posedge clk) begin
    if (cmd.rel_div) begin
      q_r        <= AW'(prod >> DIV_S);
      in_range_r <= (OW'(off_r) < OW'(n_bits));
    end
    if (cmd.rel_read) begin
      r_r <= BW'(off_r - q_base);
    end
  end

  // Memory port control
  assign rd_en   = cmd.scan_issue || cmd.rel_read;
  assign rd_addr = cmd.rel_read ? q_r : scan_addr_r;
  assign wr_en   = cmd.wr_alloc || (cmd.rel_write && !rd_zero_r);
  assign wr_data = cmd.wr_alloc ? (data_eff | low_v)
                                : (rd_data_r & ~(WORD_BITS'(1) << r_r));

  // Fill mark grows when an allocation lands on the first untouched word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.wr_alloc && ({1'b0, rd_addr_q_r} == fill_r)) begin
      fill_r <= fill_r + (AW + 1)'(1);
    end
  end

  // Pending result
  out_word_t res_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_alloc) begin
      res_r.id_out <= base_id_r + ID_W'(chk_bit_r) + ID_W'(hit_b);
      res_r.status <= ST_ALLOCATED;
    end else if (cmd.set_none) begin
      res_r.id_out <= '0;
      res_r.status <= ST_NONE_FREE;
    end else if (cmd.set_invalid) begin
      res_r.id_out <= '0;
      res_r.status <= ST_INVALID;
    end else if (cmd.rel_write) begin
      res_r.id_out <= '0;
      res_r.status <= ST_RELEASED;
    end
  end

  // Output register
  logic      out_valid_r;
  out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r <= res_r;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_word_r;

  // Status to the controller
  assign stat.in_valid  = in_if.valid;
  assign stat.in_rel    = in_if.data.req_type;
  assign stat.iss_done  = (iss_bit_r >= n_bits);
  assign stat.chk_valid = chk_valid_r;
  assign stat.hit       = chk_valid_r && (|free_v);
  assign stat.in_range  = in_range_r;
  assign stat.out_free  = !out_valid_r || out_if.ready;

endmodule

@@ rtl/bitmap_id_allocator.sv @@
// Bitmap identifier allocator, lowest free first: top level.
//
// Channels: in_if carries request words (req_type 0 asks for an id, 1 releases
// id_in); out_if returns one result word (id_out, status) per request word;
// cfg_if writes base_id (index 0) and id_count (index 1), always ready.
// All handshakes complete on a rising edge with valid and ready high.
// Allocation: after accept the scan reads bitmap words from the lowest up and
// checks each for a free bit in range; on a hit the word is written back with
// that bit set and the result loads (none free if no bit is found or the range
// is empty). The word-by-word scan loop over the bitmap memory dominates its time.
// A release runs reciprocal multiply, read, write, result; for an id out of
// range the read and write are skipped.
// Flow: one word is worked on at a time; the next request word is taken the
// cycle after the result loads, and a new word is taken while the previous
// result waits in the output register.
// Reset: synchronous, active low. Every id is free at once: a fill mark makes
// untouched memory words read as all free, so there is no clearing pass.
// When the receiver stalls, the finished result holds in the output register
// and the block stops after finishing the next word until out_if.ready rises.
module bitmap_id_allocator import bia_pkg::*; #(
  parameter int MAP_BITS  = 8192,
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  bia_in_if.sink    in_if,
  bia_out_if.source out_if,
  bia_cfg_if.sink   cfg_if
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  bia_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Bitmap datapath
  bia_dp #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

@@ tb/sv/bia_tb_pkg.sv @@
`timescale 1ns / 100ps
// Testbench package: request codes and the id pool tracker that predicts and checks result words.
package bia_tb_pkg;
  import bia_pkg::*;

  // Bitmap size of the block as built
  localparam int ID_MAP_BITS = 8192;

  // Request codes carried in req_type
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Mirrors the in-use bitmap and the two registers, queues the result words to come
  class id_pool_tracker;
    bit               used [ID_MAP_BITS];
    logic [ID_W-1:0]  base_id;
    logic [CNT_W-1:0] id_count;
    out_word_t        pending [$];
    int unsigned      mismatches;

    function new();
      base_id    = BASE_ID_RST;
      id_count   = ID_COUNT_RST;
      mismatches = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    // Register write; unknown indexes are dropped
    function void write_reg(logic [CIDX_W-1:0] index, logic [ID_W-1:0] value);
      case (index)
        CFG_BASE_ID:  base_id = value;
        CFG_ID_COUNT: id_count = value[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Number of ids actually managed, clipped to the map
    function int unsigned span();
      return (id_count > ID_MAP_BITS) ? ID_MAP_BITS : int'(id_count);
    endfunction

    // Highest in-use index inside the range, -1 when none
    function int high_mark();
      int n;
      n = span();
      for (int i = n - 1; i >= 0; i--) if (used[i]) return i;
      return -1;
    endfunction

    // Apply one accepted request word to the map and queue its result word
    function void note_request(in_word_t w);
      out_word_t   res;
      int unsigned n;
      logic [ID_W-1:0] off;
      n = span();
      res.id_out = '0;
      if (w.req_type == REQ_ALLOC) begin
        res.status = ST_NONE_FREE;
        for (int i = 0; i < n; i++) begin
          if (!used[i]) begin
            used[i]    = 1'b1;
            res.id_out = base_id + i[ID_W-1:0];
            res.status = ST_ALLOCATED;
            break;
          end
        end
      end else begin
        // offset wraps modulo 2^16
        off = w.id_in - base_id;
        if (off < n) begin
          used[off]  = 1'b0;
          res.status = ST_RELEASED;
        end else begin
          res.status = ST_INVALID;
        end
      end
      pending.push_back(res);
    endfunction

    // Compare one result word with the oldest expectation
    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word: id_out %0d status %0d",
                   $time, got.id_out, got.status);
      end else begin
        want = pending.pop_front();
        if (got.id_out !== want.id_out || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch: expected id_out %0d status %0d, got id_out %0d status %0d",
                     $time, want.id_out, want.status, got.id_out, got.status);
        end
      end
    endfunction
  endclass

endpackage

@@ tb/sv/bitmap_id_allocator_test.sv @@
`timescale 1ns / 100ps
// Top of the bitmap identifier allocator testbench: clock, reset, stimulus, result checking.
module bitmap_id_allocator_test;
  import bia_pkg::*;
  import bia_tb_pkg::*;

  localparam int RAND_ITEMS  = 1450;
  localparam int QUIET_TAIL  = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bia_in_if  in_ch ();
  bia_out_if out_ch ();
  bia_cfg_if cfg_ch ();

  id_pool_tracker pool = new();

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  bitmap_id_allocator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #2 clk = ~clk;

  // Run limit, far above the slowest legal run
  initial begin
    #8000000;
    $display("bitmap_id_allocator test failed");
    $finish;
  end

  // Result words are checked at the rising edge they are taken
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) pool.check_result(out_ch.data);
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request word, with an occasional gap before it
  task automatic offer(logic rel, logic [ID_W-1:0] id);
    in_word_t w;
    w.req_type = rel;
    w.id_in    = id;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    pool.note_request(w);
  endtask

  // Register write through the config channel
  task automatic cfg_write(logic [CIDX_W-1:0] index, logic [ID_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= index;
    cfg_ch.data.value <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    pool.write_reg(index, value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering and wait for every pending result word
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pool.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Random request word, releases aimed mostly at ids in use
  function automatic in_word_t next_word(int unsigned p_req);
    in_word_t    w;
    int unsigned roll;
    int unsigned n;
    int          hi;
    w.req_type = REQ_ALLOC;
    w.id_in    = ID_W'($urandom);
    roll = $urandom_range(0, 99);
    n    = pool.span();
    if (roll >= p_req) begin
      w.req_type = REQ_RELEASE;
      if (n != 0 && roll < 94) begin
        hi = pool.high_mark() + 1;
        if (hi >= n) hi = n - 1;
        w.id_in = pool.base_id + ID_W'($urandom_range(0, hi));
      end else if (roll < 96) begin
        w.id_in = pool.base_id + ID_W'(n);
      end else if (roll < 98) begin
        w.id_in = pool.base_id - 1'b1;
      end
    end
    return w;
  endfunction

  // Main sequence
  initial begin
    in_word_t         w;
    int               sent;
    int               ph;
    int               len;
    int unsigned      p_req;
    logic [ID_W-1:0]  nb;
    logic [ID_W-1:0]  nc;

    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: lowest-first order, release and reuse, range edges
    repeat (3) offer(REQ_ALLOC, '0);
    offer(REQ_RELEASE, pool.base_id + 1'b1);
    offer(REQ_ALLOC, '1);
    offer(REQ_RELEASE, pool.base_id - 1'b1);
    offer(REQ_RELEASE, pool.base_id + ID_W'(pool.span() - 1));
    offer(REQ_RELEASE, pool.base_id + ID_W'(pool.span()));
    offer(REQ_RELEASE, '0);
    offer(REQ_RELEASE, '1);
    settle();

    // Range that wraps past 65535, filled until none is free
    cfg_write(CFG_BASE_ID, 16'd65530);
    cfg_write(CFG_ID_COUNT, 16'd8);
    cfg_write(8'hFF, 16'h1234);
    repeat (6) offer(REQ_ALLOC, '0);
    offer(REQ_RELEASE, 16'd0);
    offer(REQ_ALLOC, '0);
    offer(REQ_RELEASE, 16'd2);
    offer(REQ_RELEASE, 16'd65529);
    settle();

    // Empty range
    cfg_write(CFG_ID_COUNT, 16'd0);
    offer(REQ_ALLOC, '0);
    offer(REQ_RELEASE, pool.base_id);
    settle();

    // Random phases, each with its own register settings
    sent = 0;
    ph   = 0;
    while (sent < RAND_ITEMS) begin
      case (ph)
        0: begin nb = '0; nc = '1; end
        1: begin nb = '1; nc = 16'd1; end
        default: begin
          case ($urandom_range(0, 3))
            0:       nb = '0;
            1:       nb = '1;
            default: nb = ID_W'($urandom);
          endcase
          case ($urandom_range(0, 11))
            0:       nc = ($urandom_range(0, 1) != 0) ? 16'd8192 : ID_W'($urandom_range(8193, 65535));
            1:       nc = 16'd0;
            2, 3:    nc = ID_W'($urandom_range(100, 600));
            default: nc = ID_W'($urandom_range(1, 48));
          endcase
        end
      endcase
      cfg_write(CFG_BASE_ID, nb);
      cfg_write(CFG_ID_COUNT, nc);
      if ($urandom_range(0, 3) == 0) cfg_write(CIDX_W'($urandom_range(2, 255)), ID_W'($urandom));
      len   = (pool.span() == 0) ? 25 : $urandom_range(60, 120);
      p_req = $urandom_range(40, 75);
      for (int k = 0; k < len && sent < RAND_ITEMS; k++) begin
        if (sent >= RAND_ITEMS - QUIET_TAIL) idle_on = 1'b0;
        if (ph == 3 && k == len / 2) hold_req = 1'b1;
        w = next_word(p_req);
        offer(w.req_type, w.id_in);
        sent++;
      end
      settle();
      ph++;
    end

    // Catch stray result words after the last one
    repeat (DRAIN_WAIT) @(negedge clk);
    if (pool.mismatches == 0 && pool.pending.size() == 0) begin
      $display("bitmap_id_allocator test passed");
    end else begin
      $display("bitmap_id_allocator test failed");
    end
    $finish;
  end

endmodule
